### hw/rtl/lsd_pkg.sv
// shared types and constants for the lzss stream decoder
// word structs, controller states, command and status groups; no dependencies
package lsd_pkg;

   localparam int LSD_WINDOW_SIZE = 4096;
   localparam logic [15:0] LSD_LIMIT_RESET = 16'hFFFF;
   localparam logic [7:0]  LSD_SPACE_BYTE = 8'd32;
   localparam logic [3:0]  LSD_GROUP_TOKENS = 4'd8;
   localparam logic [4:0]  LSD_MIN_MATCH = 5'd3;

   localparam logic [1:0] PHASE_FLAG   = 2'd0;
   localparam logic [1:0] PHASE_TOKEN  = 2'd1;
   localparam logic [1:0] PHASE_REF_HI = 2'd2;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       stream_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       limit_reached;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LIT,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_flags;
      logic load_offset;
      logic load_lit;
      logic load_copy;
      logic token_done;
      logic mem_read;
      logic emit_lit;
      logic emit_copy;
   } cmd_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       flag_bit;
      logic       under_limit;
      logic       out_free;
      logic       copy_last;
   } status_type;

endpackage

### hw/rtl/lsd_ctrl.sv
// controller state machine for the lzss stream decoder
// issues datapath commands from status; uses lsd_pkg
module lsd_ctrl import lsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (status.phase)
                  PHASE_TOKEN: begin
                     if (status.flag_bit && status.under_limit) begin
                        state_in = ST_LIT;
                     end
                  end
                  PHASE_REF_HI: begin
                     if (status.under_limit) begin
                        state_in = ST_READ;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.copy_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (status.phase)
                  PHASE_TOKEN: begin
                     if (status.flag_bit) begin
                        if (status.under_limit) begin
                           cmd.load_lit = 1'b1;
                        end else begin
                           cmd.token_done = 1'b1;
                        end
                     end else begin
                        cmd.load_offset = 1'b1;
                     end
                  end
                  PHASE_REF_HI: begin
                     if (status.under_limit) begin
                        cmd.load_copy = 1'b1;
                     end else begin
                        cmd.token_done = 1'b1;
                     end
                  end
                  default: cmd.load_flags = 1'b1;
               endcase
            end
         end
         ST_LIT: begin
            if (status.out_free) begin
               cmd.emit_lit = 1'b1;
               cmd.token_done = 1'b1;
            end
         end
         ST_READ: cmd.mem_read = 1'b1;
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_copy = 1'b1;
               cmd.token_done = status.copy_last;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

### hw/rtl/lsd_datapath.sv
// datapath for the lzss stream decoder: parser registers, history window,
// copy counters, output register and limit register; uses lsd_pkg
module lsd_datapath import lsd_pkg::*; #(
   parameter int WINDOW_SIZE = LSD_WINDOW_SIZE
) (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data,
   input  cmd_type      cmd,
   output status_type   status
);

   localparam int ADDR_W = $clog2(WINDOW_SIZE);
   localparam int WIN_START = WINDOW_SIZE - 16;
   localparam logic [ADDR_W-1:0] START_POS = ADDR_W'(WIN_START);
   localparam logic [ADDR_W:0]   FILL_FULL = (ADDR_W + 1)'(WINDOW_SIZE);

   logic [7:0]        win_mem [WINDOW_SIZE];
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff, rd_valid_in;

   logic [15:0]       limit_ff, limit_in;
   logic [15:0]       count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W:0]   fill_ff, fill_in;
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        flag_shift_ff, flag_shift_in;
   logic [3:0]        flags_left_ff, flags_left_in;
   logic [7:0]        offset_lo_ff, offset_lo_in;
   logic [7:0]        lit_ff, lit_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [4:0]        len_ff, len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              emit;
   logic [7:0]        emit_byte;
   logic [15:0]       count_plus;
   logic              at_limit;
   logic              copy_last;
   logic [3:0]        flags_dec;
   logic [ADDR_W-1:0] rel_addr;
   logic              fresh;

   assign fresh      = cmd.accept && req_word.stream_start;
   assign emit       = cmd.emit_lit || cmd.emit_copy;
   assign count_plus = count_ff + 16'd1;
   assign at_limit   = (count_plus >= limit_ff);
   assign copy_last  = (len_ff == 5'd1) || at_limit;
   assign flags_dec  = flags_left_ff - 4'd1;
   assign rel_addr   = src_ff - START_POS;
   assign rd_valid_in = ({1'b0, rel_addr} < fill_ff);

   always_comb begin
      if (cmd.emit_lit) begin
         emit_byte = lit_ff;
      end else begin
         emit_byte = rd_valid_ff ? rd_data_ff : LSD_SPACE_BYTE;
      end
   end

   always_comb begin
      status.phase       = req_word.stream_start ? PHASE_FLAG : phase_ff;
      status.flag_bit    = flag_shift_ff[0];
      status.under_limit = (req_word.stream_start ? 16'd0 : count_ff) < limit_ff;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
      status.copy_last   = copy_last;
   end

   // window store and registered read
   always_ff @(posedge clock) begin
      if (emit) begin
         win_mem[pos_ff] <= emit_byte;
      end
      if (cmd.mem_read) begin
         rd_data_ff  <= win_mem[src_ff];
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_comb begin
      limit_in      = csr_write_enable ? csr_write_data : limit_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      phase_in      = phase_ff;
      flag_shift_in = flag_shift_ff;
      flags_left_in = flags_left_ff;
      offset_lo_in  = offset_lo_ff;
      lit_in        = lit_ff;
      src_in        = src_ff;
      len_in        = len_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (fresh) begin
         count_in      = 16'd0;
         pos_in        = START_POS;
         fill_in       = '0;
         phase_in      = PHASE_FLAG;
         flag_shift_in = 8'd0;
         flags_left_in = 4'd0;
         offset_lo_in  = 8'd0;
      end
      if (cmd.load_flags) begin
         flag_shift_in = req_word.packed_byte;
         flags_left_in = LSD_GROUP_TOKENS;
         phase_in      = PHASE_TOKEN;
      end
      if (cmd.load_offset) begin
         offset_lo_in = req_word.packed_byte;
         phase_in     = PHASE_REF_HI;
      end
      if (cmd.load_lit) begin
         lit_in = req_word.packed_byte;
      end
      if (cmd.load_copy) begin
         src_in = ADDR_W'({req_word.packed_byte[7:4], offset_lo_ff});
         len_in = {1'b0, req_word.packed_byte[3:0]} + LSD_MIN_MATCH;
      end
      if (cmd.token_done) begin
         flag_shift_in = {1'b0, flag_shift_ff[7:1]};
         flags_left_in = flags_dec;
         phase_in      = (flags_dec == 4'd0) ? PHASE_FLAG : PHASE_TOKEN;
      end
      if (emit) begin
         count_in = count_plus;
         pos_in   = pos_ff + ADDR_W'(1);
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + (ADDR_W + 1)'(1);
         end
         rsp_valid_in              = 1'b1;
         rsp_word_in.out_byte      = emit_byte;
         rsp_word_in.run_last      = cmd.emit_lit ? 1'b1 : copy_last;
         rsp_word_in.limit_reached = at_limit;
      end
      if (cmd.emit_copy) begin
         src_in = src_ff + ADDR_W'(1);
         len_in = len_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LSD_LIMIT_RESET;
         count_ff      <= 16'd0;
         pos_ff        <= START_POS;
         fill_ff       <= '0;
         phase_ff      <= PHASE_FLAG;
         flag_shift_ff <= 8'd0;
         flags_left_ff <= 4'd0;
         offset_lo_ff  <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         limit_ff      <= limit_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         fill_ff       <= fill_in;
         phase_ff      <= phase_in;
         flag_shift_ff <= flag_shift_in;
         flags_left_ff <= flags_left_in;
         offset_lo_ff  <= offset_lo_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff      <= lit_in;
      src_ff      <= src_in;
      len_ff      <= len_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hw/rtl/lzss_stream_decoder_top.sv
// lzss stream decoder, one packed word in, zero to eighteen unpacked words out
// a flag or first reference word is taken while idle; a literal waits for a free output
// a back reference does a window read, then an emit, per byte; requests stall until done
// reset is synchronous; the window reads as spaces through a fill count, no clearing pass
// depends on lsd_pkg, lsd_ctrl and lsd_datapath
module lzss_stream_decoder_top import lsd_pkg::*; #(
   parameter int WINDOW_SIZE = LSD_WINDOW_SIZE
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   lsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsd_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
